[design/crwa_pkg.sv]
`default_nettype none
package crwa_pkg;

	localparam int FIELD_W      = 17;
	localparam int SUM_W        = FIELD_W + 1;
	localparam int SLOT_COUNT   = 16;
	localparam int SLOT_W       = $clog2(SLOT_COUNT);
	localparam int CNT_W        = $clog2(SLOT_COUNT + 1);
	localparam int USED_W       = 5;
	localparam int HEADER_BYTES = 4;
	localparam int NUM_REGS     = 3;
	localparam int ADDR_W       = $clog2(NUM_REGS * 4);
	localparam int REG_IDX_W    = ADDR_W - 2;
	localparam int MOD_CNT_W    = $clog2(SUM_W);

	localparam logic [FIELD_W-1:0] RING_BYTES_MAX = 17'd65536;
	localparam logic [FIELD_W-1:0] RING_BYTES_MIN = 17'd2;
	localparam logic [FIELD_W-1:0] SAT17          = '1;

	localparam logic [FIELD_W-1:0] BUF_RST = 17'd65536;
	localparam logic               BIN_RST = 1'b1;
	localparam logic [FIELD_W-1:0] THR_RST = 17'd16384;

	localparam logic [1:0] MODE_PREP = 2'd0;
	localparam logic [1:0] MODE_COMMIT = 2'd1;
	localparam logic [1:0] MODE_REL = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_RING_FULL = 2'd1;
	localparam logic [1:0] ST_QFULL = 2'd2;
	localparam logic [1:0] ST_QEMPTY = 2'd3;

	localparam logic [REG_IDX_W-1:0] REG_BUF = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_BIN = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_THR = 2'd2;

	typedef struct packed {
		logic [FIELD_W-1:0] size;
		logic               bin;
		logic [FIELD_W-1:0] thr;
	} cfg_t;

	typedef struct packed {
		logic               start;
		logic               ack;
		logic [SUM_W-1:0]   dividend;
		logic [FIELD_W-1:0] divisor;
	} mod_req_t;

	typedef struct packed {
		logic               done;
		logic [FIELD_W-1:0] rem;
	} mod_rsp_t;

endpackage
`default_nettype wire

[design/crwa_if.sv]
`default_nettype none
interface crwa_in_if import crwa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         mode;
	logic [FIELD_W-1:0] byte_count;
	logic [FIELD_W-1:0] skipped_gap;
	logic               allow_zero_copy;

	modport source (output valid, mode, byte_count, skipped_gap, allow_zero_copy, input ready);
	modport sink (input valid, mode, byte_count, skipped_gap, allow_zero_copy, output ready);
endinterface

interface crwa_out_if import crwa_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [FIELD_W-1:0] offset;
	logic [FIELD_W-1:0] gap_out;
	logic [FIELD_W-1:0] length_prefix;
	logic               zero_copy;
	logic [FIELD_W-1:0] frame_length;
	logic [USED_W-1:0]  slots_used;

	modport source (output valid, status, offset, gap_out, length_prefix, zero_copy,
		frame_length, slots_used, input ready);
	modport sink (input valid, status, offset, gap_out, length_prefix, zero_copy,
		frame_length, slots_used, output ready);
endinterface
`default_nettype wire

[design/crwa_cfg.sv]
`default_nettype none
module crwa_cfg import crwa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	logic [FIELD_W-1:0]   buf_q;
	logic                 bin_q;
	logic [FIELD_W-1:0]   thr_q;
	logic [FIELD_W-1:0]   size_q;
	logic [FIELD_W-1:0]   wdata17;
	logic [FIELD_W-1:0]   clamped;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr;

	assign pready  = 1'b1;
	assign idx     = paddr[ADDR_W-1:2];
	assign wr      = psel && penable && pwrite;
	assign wdata17 = pwdata[FIELD_W-1:0];

	always_comb begin
		if (wdata17 < RING_BYTES_MIN) begin
			clamped = RING_BYTES_MIN;
		end else if (wdata17 > RING_BYTES_MAX) begin
			clamped = RING_BYTES_MAX;
		end else begin
			clamped = wdata17;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_q  <= BUF_RST;
			bin_q  <= BIN_RST;
			thr_q  <= THR_RST;
			size_q <= BUF_RST;
		end else if (wr) begin
			case (idx)
				REG_BUF: begin
					buf_q  <= wdata17;
					size_q <= clamped;
				end
				REG_BIN: bin_q <= pwdata[0];
				REG_THR: thr_q <= wdata17;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BUF: prdata = 32'(buf_q);
			REG_BIN: prdata = 32'(bin_q);
			REG_THR: prdata = 32'(thr_q);
			default: prdata = '0;
		endcase
	end

	assign cfg.size = size_q;
	assign cfg.bin  = bin_q;
	assign cfg.thr  = thr_q;

endmodule
`default_nettype wire

[design/crwa_mod.sv]
`default_nettype none
module crwa_mod import crwa_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  mod_req_t  req,
	output mod_rsp_t  rsp
);

	typedef enum logic [1:0] {IDLE, RUN, DONE} mod_state_t;

	mod_state_t           state_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [SUM_W-1:0]     dvd_q;
	logic [FIELD_W-1:0]   div_q;
	logic [FIELD_W-1:0]   rem_q;
	logic [SUM_W-1:0]     rem_sh;
	logic [FIELD_W-1:0]   rem_nxt;

	// one quotient bit per cycle, restoring
	always_comb begin
		rem_sh = {rem_q, dvd_q[SUM_W-1]};
		if (rem_sh >= {1'b0, div_q}) begin
			rem_nxt = FIELD_W'(rem_sh - {1'b0, div_q});
		end else begin
			rem_nxt = rem_sh[FIELD_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (req.start) begin
						state_q <= RUN;
						cnt_q   <= '0;
					end
				end
				RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == MOD_CNT_W'(SUM_W - 1)) begin
						state_q <= DONE;
					end
				end
				DONE: begin
					if (req.ack) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
		end else if (state_q == RUN) begin
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
			rem_q <= rem_nxt;
		end
	end

	assign rsp.done = (state_q == DONE);
	assign rsp.rem  = rem_q;

endmodule
`default_nettype wire

[design/contiguous_ring_write_allocator.sv]
// A beat accepted into the input register moves to the registered result stage when it advances.
// Throughput: one beat per cycle while the output is not stalled, set by the single input
//   and result register pair. A release whose new tail needs reduction past twice the ring
//   size holds the input stage in the bit-serial remainder unit until its remainder is done.
// Reset (arst_n, async, active low): clears offsets, slot pointers, slot count,
//   stage valids and registers to defaults; the slot store is not cleared.
`default_nettype none
module contiguous_ring_write_allocator import crwa_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	crwa_in_if.sink                in_ch,
	crwa_out_if.source             out_ch
);

	cfg_t     cfg;
	mod_req_t mod_req;
	mod_rsp_t mod_rsp;

	logic               vld_s1;
	logic [1:0]         mode_s1;
	logic [FIELD_W-1:0] count_s1;
	logic [FIELD_W-1:0] gap_s1;
	logic               allow_s1;

	logic               vld_s2;
	logic [1:0]         status_s2;
	logic [FIELD_W-1:0] offset_s2;
	logic [FIELD_W-1:0] gap_out_s2;
	logic [FIELD_W-1:0] prefix_s2;
	logic               zc_s2;
	logic [FIELD_W-1:0] flen_s2;
	logic [USED_W-1:0]  used_s2;

	logic [FIELD_W-1:0] head_q;
	logic [FIELD_W-1:0] tail_q;
	logic [SLOT_W-1:0]  wr_ptr_q;
	logic [SLOT_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	logic [FIELD_W-1:0] slot_gap_q [SLOT_COUNT];
	logic [FIELD_W-1:0] slot_len_q [SLOT_COUNT];
	logic               slot_zc_q  [SLOT_COUNT];

	logic               out_free;
	logic               advance;
	logic               need_slow;
	logic               slot_wr;

	logic [FIELD_W-1:0] at_end;
	logic [SUM_W-1:0]   c_total;
	logic [FIELD_W-1:0] c_flen;
	logic [SUM_W-1:0]   c_head_sum;
	logic [FIELD_W-1:0] r_gap;
	logic [FIELD_W-1:0] r_len;
	logic               r_zc;
	logic [FIELD_W-1:0] r_base;
	logic [SUM_W-1:0]   r_sum;
	logic [SUM_W-1:0]   size2;

	logic [1:0]         res_status;
	logic [FIELD_W-1:0] res_offset;
	logic [FIELD_W-1:0] res_gap;
	logic [FIELD_W-1:0] res_prefix;
	logic               res_zc;
	logic [FIELD_W-1:0] res_flen;
	logic [FIELD_W-1:0] head_nxt;
	logic [FIELD_W-1:0] tail_nxt;
	logic [SLOT_W-1:0]  wr_ptr_nxt;
	logic [SLOT_W-1:0]  rd_ptr_nxt;
	logic [CNT_W-1:0]   cnt_nxt;

	crwa_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	crwa_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	assign at_end     = (head_q <= cfg.size) ? FIELD_W'(cfg.size - head_q) : '0;
	assign c_total    = {1'b0, count_s1} + (cfg.bin ? SUM_W'(HEADER_BYTES) : '0);
	assign c_flen     = c_total[SUM_W-1] ? SAT17 : c_total[FIELD_W-1:0];
	assign c_head_sum = {1'b0, head_q} + {1'b0, c_flen};
	assign r_gap      = slot_gap_q[rd_ptr_q];
	assign r_len      = slot_len_q[rd_ptr_q];
	assign r_zc       = slot_zc_q[rd_ptr_q];
	assign r_base     = (r_gap != '0) ? '0 : tail_q;
	assign r_sum      = {1'b0, r_base} + {1'b0, r_len};
	assign size2      = {cfg.size, 1'b0};

	assign need_slow = vld_s1 && (mode_s1 == MODE_REL) && (cnt_q != '0) &&
		(r_len != '0) && (r_sum >= size2);

	assign out_free    = !vld_s2 || out_ch.ready;
	assign advance     = vld_s1 && out_free && (!need_slow || mod_rsp.done);
	assign in_ch.ready = !vld_s1 || advance;

	assign mod_req.start    = need_slow;
	assign mod_req.ack      = advance && need_slow;
	assign mod_req.dividend = r_sum;
	assign mod_req.divisor  = cfg.size;

	always_comb begin
		res_status = ST_OK;
		res_offset = '0;
		res_gap    = '0;
		res_prefix = '0;
		res_zc     = 1'b0;
		res_flen   = '0;
		head_nxt   = head_q;
		tail_nxt   = tail_q;
		wr_ptr_nxt = wr_ptr_q;
		rd_ptr_nxt = rd_ptr_q;
		cnt_nxt    = cnt_q;
		slot_wr    = 1'b0;
		case (mode_s1)
			MODE_PREP: begin
				if (count_s1 <= at_end) begin
					if (tail_q > head_q && count_s1 >= FIELD_W'(tail_q - head_q)) begin
						res_status = ST_RING_FULL;
					end
				end else if (tail_q > head_q || tail_q == '0 || count_s1 >= tail_q) begin
					res_status = ST_RING_FULL;
				end else begin
					res_gap  = at_end;
					head_nxt = '0;
				end
				res_offset = head_nxt;
			end
			MODE_COMMIT: begin
				res_offset = head_q;
				if (cnt_q >= CNT_W'(SLOT_COUNT)) begin
					res_status = ST_QFULL;
				end else begin
					res_flen   = c_flen;
					res_prefix = cfg.bin ? count_s1 : '0;
					res_zc     = allow_s1 && cfg.bin && (c_flen > cfg.thr);
					head_nxt   = c_head_sum[SUM_W-1] ? SAT17 : c_head_sum[FIELD_W-1:0];
					wr_ptr_nxt = (wr_ptr_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : wr_ptr_q + 1'b1;
					cnt_nxt    = cnt_q + 1'b1;
					slot_wr    = 1'b1;
				end
			end
			MODE_REL: begin
				if (cnt_q == '0) begin
					res_status = ST_QEMPTY;
				end else begin
					res_gap  = r_gap;
					res_flen = r_len;
					res_zc   = r_zc;
					if (r_len == '0) begin
						tail_nxt = r_base;
					end else if (r_sum < {1'b0, cfg.size}) begin
						tail_nxt = r_sum[FIELD_W-1:0];
					end else if (r_sum < size2) begin
						tail_nxt = FIELD_W'(r_sum - {1'b0, cfg.size});
					end else begin
						tail_nxt = mod_rsp.rem;
					end
					rd_ptr_nxt = (rd_ptr_q == SLOT_W'(SLOT_COUNT - 1)) ? '0 : rd_ptr_q + 1'b1;
					cnt_nxt    = cnt_q - 1'b1;
				end
				res_offset = tail_nxt;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (in_ch.ready) begin
				vld_s1 <= in_ch.valid;
			end
			if (advance && mode_s1 != MODE_NONE) begin
				vld_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				vld_s2 <= 1'b0;
			end
			if (advance) begin
				head_q   <= head_nxt;
				tail_q   <= tail_nxt;
				wr_ptr_q <= wr_ptr_nxt;
				rd_ptr_q <= rd_ptr_nxt;
				cnt_q    <= cnt_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			mode_s1  <= in_ch.mode;
			count_s1 <= in_ch.byte_count;
			gap_s1   <= in_ch.skipped_gap;
			allow_s1 <= in_ch.allow_zero_copy;
		end
		if (advance) begin
			status_s2  <= res_status;
			offset_s2  <= res_offset;
			gap_out_s2 <= res_gap;
			prefix_s2  <= res_prefix;
			zc_s2      <= res_zc;
			flen_s2    <= res_flen;
			used_s2    <= USED_W'(cnt_nxt);
		end
		if (advance && slot_wr) begin
			slot_gap_q[wr_ptr_q] <= gap_s1;
			slot_len_q[wr_ptr_q] <= c_flen;
			slot_zc_q[wr_ptr_q]  <= res_zc;
		end
	end

	assign out_ch.valid         = vld_s2;
	assign out_ch.status        = status_s2;
	assign out_ch.offset        = offset_s2;
	assign out_ch.gap_out       = gap_out_s2;
	assign out_ch.length_prefix = prefix_s2;
	assign out_ch.zero_copy     = zc_s2;
	assign out_ch.frame_length  = flen_s2;
	assign out_ch.slots_used    = used_s2;

endmodule
`default_nettype wire

[design/crwa_checker.sv]
`default_nettype none
module crwa_checker import crwa_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [1:0]         status,
	input wire logic [FIELD_W-1:0] offset,
	input wire logic               zero_copy,
	input wire logic [FIELD_W-1:0] frame_length,
	input wire logic [USED_W-1:0]  slots_used
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(offset) &&
		$stable(frame_length) && $stable(slots_used))
		else $error("result beat changed while stalled");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_QEMPTY |-> slots_used == '0 && frame_length == '0 &&
		!zero_copy)
		else $error("empty-queue release reports a slot");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_QFULL |-> slots_used == USED_W'(SLOT_COUNT) &&
		frame_length == '0)
		else $error("full-queue commit with wrong count");

	a_reset_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result beat right after reset");

endmodule

bind contiguous_ring_write_allocator crwa_checker u_crwa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.status       (out_ch.status),
	.offset       (out_ch.offset),
	.zero_copy    (out_ch.zero_copy),
	.frame_length (out_ch.frame_length),
	.slots_used   (out_ch.slots_used)
);
`default_nettype wire

[tb/crwa_alloc_monitor.sv]
`timescale 1ns / 100ps
module crwa_alloc_monitor import crwa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic              pready,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	crwa_in_if                in_mon,
	crwa_out_if               out_mon,
	output int                fail_count,
	output int                pending
);

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] offset;
		logic [FIELD_W-1:0] gap;
		logic [FIELD_W-1:0] prefix;
		logic               zc;
		logic [FIELD_W-1:0] flen;
		logic [USED_W-1:0]  used;
	} alloc_result_t;

	cfg_t               cfg;
	logic [FIELD_W-1:0] head;
	logic [FIELD_W-1:0] tail;
	logic [SLOT_W-1:0]  wr_ptr;
	logic [SLOT_W-1:0]  rd_ptr;
	logic [CNT_W-1:0]   live_slots;
	logic [FIELD_W-1:0] slot_gap_mem [SLOT_COUNT];
	logic [FIELD_W-1:0] slot_len_mem [SLOT_COUNT];
	logic               slot_zc_mem [SLOT_COUNT];
	alloc_result_t      alloc_expect_q [$];

	function automatic bit alloc_step(input logic [1:0] op, input logic [FIELD_W-1:0] cnt,
			input logic [FIELD_W-1:0] gap_in, input logic allow, output alloc_result_t r);
		int unsigned ring;
		int unsigned at_end;
		int unsigned sum;
		r = '0;
		if (op == MODE_NONE)
			return 1'b0;
		ring = 32'(cfg.size);
		if (ring < 32'(RING_BYTES_MIN))
			ring = 32'(RING_BYTES_MIN);
		if (ring > 32'(RING_BYTES_MAX))
			ring = 32'(RING_BYTES_MAX);
		case (op)
		MODE_PREP: begin
			at_end = (32'(head) <= ring) ? ring - 32'(head) : 0;
			if (32'(cnt) <= at_end) begin
				// would run into live bytes ahead of the head
				if (tail > head && cnt >= FIELD_W'(tail - head))
					r.status = ST_RING_FULL;
			end else if (tail > head || tail == '0 || cnt >= tail) begin
				r.status = ST_RING_FULL;
			end else begin
				r.gap = at_end[FIELD_W-1:0];
				head = '0;
			end
			r.offset = head;
		end
		MODE_COMMIT: begin
			r.offset = head;
			if (live_slots >= CNT_W'(SLOT_COUNT)) begin
				r.status = ST_QFULL;
			end else begin
				sum = 32'(cnt) + (cfg.bin ? 32'(HEADER_BYTES) : 32'd0);
				r.flen = (sum > 32'(SAT17)) ? SAT17 : sum[FIELD_W-1:0];
				r.prefix = cfg.bin ? cnt : '0;
				r.zc = allow && cfg.bin && (r.flen > cfg.thr);
				slot_gap_mem[wr_ptr] = gap_in;
				slot_len_mem[wr_ptr] = r.flen;
				slot_zc_mem[wr_ptr] = r.zc;
				sum = 32'(head) + 32'(r.flen);
				head = (sum > 32'(SAT17)) ? SAT17 : sum[FIELD_W-1:0];
				wr_ptr = wr_ptr + 1'b1;
				live_slots = live_slots + 1'b1;
			end
		end
		default: begin
			if (live_slots == '0) begin
				r.status = ST_QEMPTY;
			end else begin
				r.gap = slot_gap_mem[rd_ptr];
				r.flen = slot_len_mem[rd_ptr];
				r.zc = slot_zc_mem[rd_ptr];
				if (r.gap != '0)
					tail = '0;
				if (r.flen != '0) begin
					sum = (32'(tail) + 32'(r.flen)) % ring;
					tail = sum[FIELD_W-1:0];
				end
				rd_ptr = rd_ptr + 1'b1;
				live_slots = live_slots - 1'b1;
			end
			r.offset = tail;
		end
		endcase
		r.used = USED_W'(live_slots);
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		alloc_result_t want;
		if (!arst_n) begin
			cfg = '{size: BUF_RST, bin: BIN_RST, thr: THR_RST};
			head = '0;
			tail = '0;
			wr_ptr = '0;
			rd_ptr = '0;
			live_slots = '0;
			alloc_expect_q.delete();
			pending = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[ADDR_W-1:2])
				REG_BUF: cfg.size = pwdata[FIELD_W-1:0];
				REG_BIN: cfg.bin = pwdata[0];
				REG_THR: cfg.thr = pwdata[FIELD_W-1:0];
				default: ;
				endcase
			end
			if (in_mon.valid && in_mon.ready) begin
				if (alloc_step(in_mon.mode, in_mon.byte_count, in_mon.skipped_gap,
						in_mon.allow_zero_copy, want))
					alloc_expect_q.push_back(want);
			end
			if (out_mon.valid && out_mon.ready) begin
				if (alloc_expect_q.size() == 0) begin
					$error("result beat with no prediction pending");
					fail_count++;
				end else begin
					want = alloc_expect_q.pop_front();
					check_field("status", 32'(want.status), 32'(out_mon.status));
					check_field("offset", 32'(want.offset), 32'(out_mon.offset));
					check_field("gap_out", 32'(want.gap), 32'(out_mon.gap_out));
					check_field("length_prefix", 32'(want.prefix),
						32'(out_mon.length_prefix));
					check_field("zero_copy", 32'(want.zc), 32'(out_mon.zero_copy));
					check_field("frame_length", 32'(want.flen), 32'(out_mon.frame_length));
					check_field("slots_used", 32'(want.used), 32'(out_mon.slots_used));
				end
			end
			pending = alloc_expect_q.size();
		end
	end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
	import crwa_pkg::*;

	localparam int CYCLE_LIMIT     = 1_000_000;
	localparam int SETTLE_CYCLES   = 40;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 240;

	typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_PERIODIC} rdy_style_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic               pready;
	logic [ADDR_W-1:0]  paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	int                 fail_count;
	int                 pending;
	int                 cycles = 0;
	int                 burst_left = 0;
	int                 sent = 0;
	int                 stall_left = 0;
	rdy_style_t         rdy_style = RDY_ALWAYS;
	logic [1:0]         last_status;
	logic [FIELD_W-1:0] last_gap;
	cfg_t               cur_cfg;

	crwa_in_if in_ch();
	crwa_out_if out_ch();

	contiguous_ring_write_allocator dut (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
		.in_ch(in_ch), .out_ch(out_ch)
	);

	crwa_alloc_monitor alloc_mon (
		.clk, .arst_n, .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.in_mon(in_ch), .out_mon(out_ch), .fail_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left == 0) begin
			rdy_style <= rdy_style_t'($urandom_range(0, 3));
			stall_left <= $urandom_range(30, 300);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (rdy_style)
		RDY_ALWAYS: out_ch.ready <= 1'b1;
		RDY_COIN: out_ch.ready <= 1'($urandom_range(0, 1));
		RDY_MOSTLY: out_ch.ready <= ($urandom_range(0, 9) != 0);
		default: out_ch.ready <= (cycles % 8) < 5;
		endcase
	end

	task automatic issue(input logic [1:0] op, input logic [FIELD_W-1:0] count,
			input logic [FIELD_W-1:0] gap, input logic allow);
		int idle;
		if (burst_left <= 0) begin
			idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (idle > 0) begin
				in_ch.valid <= 1'b0;
				repeat (idle) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= op;
		in_ch.byte_count <= count;
		in_ch.skipped_gap <= gap;
		in_ch.allow_zero_copy <= allow;
		do @(posedge clk); while (!in_ch.ready);
		burst_left--;
		if (op != MODE_NONE)
			sent++;
	endtask

	// hold off the sender until every predicted beat is back; keeps the last one seen
	task automatic drain();
		in_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				last_status = out_ch.status;
				last_gap = out_ch.gap_out;
			end
		end while (pending != 0);
	endtask

	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	initial begin : stimulus
		int   ring;
		int   content;
		int   need;
		int   rel_pct;
		int   pick;
		logic allow;
		cfg_t phase_cfg [PHASES];
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_PREP;
		in_ch.byte_count = '0;
		in_ch.skipped_gap = '0;
		in_ch.allow_zero_copy = 1'b0;
		out_ch.ready = 1'b0;
		cur_cfg = '{size: BUF_RST, bin: BIN_RST, thr: THR_RST};
		phase_cfg[0] = '{size: 17'd64, bin: 1'b1, thr: 17'd20};
		phase_cfg[1] = '{size: 17'd2, bin: 1'b0, thr: 17'd0};
		phase_cfg[2] = '{size: 17'd65536, bin: 1'b1, thr: 17'd65536};
		phase_cfg[3] = '{size: 17'd0, bin: 1'b1, thr: 17'd0};
		phase_cfg[4] = '{size: 17'h1FFFF, bin: 1'b0, thr: 17'h1FFFF};
		phase_cfg[5] = '{size: 17'($urandom_range(16, 4096)), bin: 1'b1,
			thr: 17'($urandom_range(0, 4100))};
		phase_cfg[6] = '{size: 17'($urandom_range(2, 300)), bin: 1'($urandom_range(0, 1)),
			thr: 17'($urandom_range(0, 131071))};
		phase_cfg[7] = '{size: 17'd1000, bin: 1'b1, thr: 17'd500};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: 64K ring, binary framing, threshold 16K
		issue(MODE_REL, 0, 0, 0);
		issue(MODE_PREP, 0, 0, 0);
		issue(MODE_COMMIT, 0, 0, 1);
		issue(MODE_PREP, 17'd65536, 0, 0);
		issue(MODE_PREP, 17'd20000, 0, 0);
		issue(MODE_COMMIT, 17'd20000, 0, 1);
		issue(MODE_COMMIT, 17'd100, 0, 0);
		issue(MODE_NONE, 17'h1FFFF, 17'h1FFFF, 1);
		issue(MODE_REL, 0, 0, 0);
		issue(MODE_REL, 0, 0, 0);
		issue(MODE_COMMIT, 17'h1FFFF, 0, 1);
		issue(MODE_PREP, 17'd10, 0, 0);
		issue(MODE_COMMIT, 17'd10, 0, 0);
		issue(MODE_PREP, 17'd30000, 0, 0);
		issue(MODE_PREP, 17'd100, 0, 0);
		issue(MODE_COMMIT, 17'd100, 17'd65536, 0);
		issue(MODE_REL, 0, 0, 0);
		issue(MODE_REL, 0, 0, 0);
		issue(MODE_REL, 0, 0, 0);
		issue(MODE_REL, 0, 0, 0);
		issue(MODE_REL, 0, 0, 0);

		for (int p = 0; p < PHASES; p++) begin
			drain();
			repeat (SETTLE_CYCLES) @(posedge clk);
			cur_cfg = phase_cfg[p];
			reg_write(REG_BUF, 32'(cur_cfg.size));
			reg_write(REG_BIN, 32'(cur_cfg.bin));
			reg_write(REG_THR, 32'(cur_cfg.thr));
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			ring = 32'(cur_cfg.size);
			if (ring < 32'(RING_BYTES_MIN))
				ring = 32'(RING_BYTES_MIN);
			if (ring > 32'(RING_BYTES_MAX))
				ring = 32'(RING_BYTES_MAX);
			rel_pct = $urandom_range(12, 45);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				pick = $urandom_range(0, 99);
				if (pick < 6) begin
					issue(2'($urandom_range(0, 3)), FIELD_W'($urandom_range(0, 131071)),
						FIELD_W'($urandom_range(0, 131071)), 1'($urandom_range(0, 1)));
				end else if (pick < 6 + rel_pct) begin
					issue(MODE_REL, FIELD_W'($urandom_range(0, 131071)),
						FIELD_W'($urandom_range(0, 131071)), 1'($urandom_range(0, 1)));
				end else begin
					pick = $urandom_range(0, 99);
					if (pick < 2)
						content = $urandom_range(0, 131071);
					else if (pick < 12)
						content = $urandom_range(0, ring);
					else
						content = $urandom_range(0, ring / 4 + 1);
					need = content + (cur_cfg.bin ? HEADER_BYTES : 0);
					if (need > 131071)
						need = 131071;
					allow = 1'($urandom_range(0, 1));
					issue(MODE_PREP, FIELD_W'(need), FIELD_W'($urandom_range(0, 131071)), allow);
					if ($urandom_range(0, 3) != 0) begin
						drain();
						if (last_status == ST_OK || $urandom_range(0, 9) == 0)
							issue(MODE_COMMIT, FIELD_W'(content), last_gap, allow);
						else
							issue(MODE_REL, 0, 0, 0);
					end else begin
						issue(MODE_COMMIT, FIELD_W'(content),
							($urandom_range(0, 3) == 0) ? FIELD_W'($urandom_range(0, 131071)) :
							FIELD_W'(0), allow);
					end
				end
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
